[src/assert_macros.svh]
// Shared assertion macros for the encoder checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, held off in reset.
`define RFPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RFPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/rfpe_pkg.sv]
package rfpe_pkg;

  localparam int unsigned IdBitsDef  = 16;
  localparam int unsigned KeyBitsDef = 7;

  localparam int unsigned WidthW   = 12;
  localparam int unsigned RepeatW  = 8;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [WidthW-1:0]  StartWidthRst  = 12'd520;
  localparam logic [WidthW-1:0]  ShortWidthRst  = 12'd110;
  localparam logic [WidthW-1:0]  LongWidthRst   = 12'd290;
  localparam logic [RepeatW-1:0] RepeatCountRst = 8'd100;
  localparam logic               InvertRst      = 1'b0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_WIDTH  = 3'd0,
    CFG_SHORT_WIDTH  = 3'd1,
    CFG_LONG_WIDTH   = 3'd2,
    CFG_REPEAT_COUNT = 3'd3,
    CFG_INVERT_START = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SEND = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   operation;
    logic [IdBitsDef-1:0]  remote_id;
    logic [KeyBitsDef-1:0] keycode;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
  } out_t;

  typedef struct packed {
    logic [WidthW-1:0]  start_width;
    logic [WidthW-1:0]  short_width;
    logic [WidthW-1:0]  long_width;
    logic [RepeatW-1:0] repeat_count;
    logic               invert_start;
  } cfg_t;

endpackage

[src/rf_remote_pulse_encoder.sv]
// Pulse-train encoder for a simple remote-control radio link. Each input
// transaction is either one microsecond tick or a send command carrying a
// 16-bit remote id and a 7-bit keycode; every transaction yields exactly one
// result transaction holding the line level and the busy flag after it. A
// send starts repeat_count+1 frames (start pulse, then the code word msb
// first: a zero is two short pulses, a one is one long pulse that flips the
// tracked level); a send while busy is dropped but still answered. The block
// takes one transaction per clock unless in_stall_o is high; the whole state
// update is one short pass of logic through the pulse counter and the code
// shift register; the result is registered into a two-entry output buffer.
// in_stall_o rises only while both buffer entries wait on a stalled output.
// Configuration writes are registered and belong in idle periods.
module rf_remote_pulse_encoder #(
  parameter int unsigned ID_BITS  = rfpe_pkg::IdBitsDef,
  parameter int unsigned KEY_BITS = rfpe_pkg::KeyBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rfpe_pkg::in_t                 in_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rfpe_pkg::out_t                out_data_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [rfpe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rfpe_pkg::CfgDataW-1:0] cfg_data_i
);

  rfpe_pkg::cfg_t cfg;
  rfpe_pkg::out_t res;
  logic           fire;
  logic           buf_full;

  // Accept while the output buffer has a free entry.
  assign in_stall_o = buf_full;
  assign fire       = in_valid_i && !buf_full;

  rfpe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Advance the pulse state on every accepted transaction.
  rfpe_core #(
    .ID_BITS  (ID_BITS),
    .KEY_BITS (KEY_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Hold results until the downstream side takes them.
  rfpe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/rfpe_cfg.sv]
module rfpe_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rfpe_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rfpe_pkg::CfgDataW-1:0]       cfg_data_i,
  output rfpe_pkg::cfg_t                      cfg_o
);

  rfpe_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (rfpe_pkg::cfg_idx_e'(cfg_idx_i))
        rfpe_pkg::CFG_START_WIDTH:  cfg_d.start_width  = cfg_data_i;
        rfpe_pkg::CFG_SHORT_WIDTH:  cfg_d.short_width  = cfg_data_i;
        rfpe_pkg::CFG_LONG_WIDTH:   cfg_d.long_width   = cfg_data_i;
        rfpe_pkg::CFG_REPEAT_COUNT: cfg_d.repeat_count = cfg_data_i[rfpe_pkg::RepeatW-1:0];
        rfpe_pkg::CFG_INVERT_START: cfg_d.invert_start = cfg_data_i[0];
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_width  <= rfpe_pkg::StartWidthRst;
      cfg_q.short_width  <= rfpe_pkg::ShortWidthRst;
      cfg_q.long_width   <= rfpe_pkg::LongWidthRst;
      cfg_q.repeat_count <= rfpe_pkg::RepeatCountRst;
      cfg_q.invert_start <= rfpe_pkg::InvertRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/rfpe_core.sv]
module rfpe_core #(
  parameter int unsigned ID_BITS  = rfpe_pkg::IdBitsDef,
  parameter int unsigned KEY_BITS = rfpe_pkg::KeyBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  rfpe_pkg::in_t  in_data_i,
  input  rfpe_pkg::cfg_t cfg_i,
  output rfpe_pkg::out_t res_o
);

  localparam int unsigned CodeBits = ID_BITS + KEY_BITS;
  localparam int unsigned BidxW    = $clog2(CodeBits + 1);

  logic [CodeBits-1:0]              code_d, code_q;
  logic [BidxW-1:0]                 bidx_d, bidx_q;
  logic [rfpe_pkg::WidthW-1:0]      ticks_d, ticks_q;
  logic [rfpe_pkg::RepeatW-1:0]     frames_d, frames_q;
  logic                             line_d, line_q;
  logic                             busy_d, busy_q;
  logic                             half_d, half_q;
  logic                             level_d, level_q;
  logic                             start_lvl;

  assign start_lvl = ~cfg_i.invert_start;

  always_comb begin
    code_d   = code_q;
    bidx_d   = bidx_q;
    ticks_d  = ticks_q;
    frames_d = frames_q;
    line_d   = line_q;
    busy_d   = busy_q;
    half_d   = half_q;
    level_d  = level_q;
    if (fire_i) begin
      if (in_data_i.operation == rfpe_pkg::OP_SEND) begin
        if (!busy_q) begin
          code_d   = {ID_BITS'(in_data_i.remote_id), KEY_BITS'(in_data_i.keycode)};
          frames_d = cfg_i.repeat_count;
          busy_d   = 1'b1;
          level_d  = start_lvl;
          bidx_d   = BidxW'(CodeBits);
          half_d   = 1'b0;
          line_d   = start_lvl;
          ticks_d  = cfg_i.start_width;
        end
      end else if (busy_q) begin
        if (ticks_q > rfpe_pkg::WidthW'(1)) begin
          ticks_d = ticks_q - rfpe_pkg::WidthW'(1);
        end else if (half_q) begin
          half_d  = 1'b0;
          line_d  = level_q;
          ticks_d = cfg_i.short_width;
        end else if (bidx_q != '0) begin
          // shift out the next code bit, msb first
          bidx_d = bidx_q - BidxW'(1);
          code_d = code_q << 1;
          line_d = ~level_q;
          if (code_q[CodeBits-1]) begin
            ticks_d = cfg_i.long_width;
            level_d = ~level_q;
          end else begin
            ticks_d = cfg_i.short_width;
            half_d  = 1'b1;
          end
        end else if (frames_q != '0) begin
          frames_d = frames_q - rfpe_pkg::RepeatW'(1);
          level_d  = start_lvl;
          bidx_d   = BidxW'(CodeBits);
          half_d   = 1'b0;
          line_d   = start_lvl;
          ticks_d  = cfg_i.start_width;
          // code_q was shifted out; reload it from the saved copy below
          code_d   = code_q;
        end else begin
          busy_d  = 1'b0;
          line_d  = ~level_q;
          ticks_d = '0;
        end
      end
    end
  end

  // Frame repeats need the original word: keep an unshifted copy.
  logic [CodeBits-1:0] word_d, word_q;

  always_comb begin
    word_d = word_q;
    if (fire_i && in_data_i.operation == rfpe_pkg::OP_SEND && !busy_q) begin
      word_d = code_d;
    end
  end

  logic [CodeBits-1:0] code_sel;

  always_comb begin
    code_sel = code_d;
    if (fire_i && in_data_i.operation == rfpe_pkg::OP_TICK && busy_q &&
        ticks_q <= rfpe_pkg::WidthW'(1) && !half_q && bidx_q == '0 && frames_q != '0) begin
      code_sel = word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q   <= '0;
      word_q   <= '0;
      bidx_q   <= '0;
      ticks_q  <= '0;
      frames_q <= '0;
      line_q   <= 1'b0;
      busy_q   <= 1'b0;
      half_q   <= 1'b0;
      level_q  <= 1'b0;
    end else begin
      code_q   <= code_sel;
      word_q   <= word_d;
      bidx_q   <= bidx_d;
      ticks_q  <= ticks_d;
      frames_q <= frames_d;
      line_q   <= line_d;
      busy_q   <= busy_d;
      half_q   <= half_d;
      level_q  <= level_d;
    end
  end

  assign res_o.line_level = line_d;
  assign res_o.busy_res   = busy_d;

endmodule

[src/rfpe_out_buf.sv]
module rfpe_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfpe_pkg::out_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rfpe_pkg::out_t out_data_o
);

  rfpe_pkg::out_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     count_q, count_d;
  logic           pop;

  assign pop = out_valid_o && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  assign full_o      = count_q[1];
  assign out_valid_o = count_q != 2'd0;
  assign out_data_o  = mem_q[rptr_q];

endmodule

[src/rfpe_checker.sv]
`include "assert_macros.svh"

module rfpe_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input rfpe_pkg::out_t                out_data_o
);

  logic out_fire;
  logic prev_busy_q, prev_line_q;

  assign out_fire = out_valid_o && !out_stall_i;

  // Track the last delivered result; reset matches an idle, low line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_busy_q <= 1'b0;
      prev_line_q <= 1'b0;
    end else if (out_fire) begin
      prev_busy_q <= out_data_o.busy_res;
      prev_line_q <= out_data_o.line_level;
    end
  end

  `RFPE_ASSERT_NOW(a_idle_line_holds, clk_i, rst_ni, out_fire && !prev_busy_q && !out_data_o.busy_res, out_data_o.line_level == prev_line_q, "line moved while idle")
  `RFPE_ASSERT_NOW(a_stall_means_backlog, clk_i, rst_ni, in_stall_o, out_valid_o, "input stalled with no pending result")
  `RFPE_ASSERT_NOW(a_result_has_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o), "result without accepted input")
  `RFPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind rf_remote_pulse_encoder rfpe_checker u_rfpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
